// ----- design/assert_macros.svh -----
// assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define BPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bpa_pkg.sv -----
package bpa_pkg;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_REBUILD = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_BAD_ORD  = 2'd2
   } status_type;

   localparam int unsigned CSR_POOL_START = 0;
   localparam int unsigned CSR_POOL_END   = 1;
   localparam logic [12:0] COUNT_MAX      = 13'd8191;

   // largest block order and size of the page store
   localparam int LARGEST_ORDER = 10;
   localparam int POOL_PAGES    = 4096;

endpackage

// ----- design/buddy_page_allocator.sv -----
// buddy page allocator, free lists linked through a page-indexed link memory
// alloc: searches upward from the requested order, pops a block and splits it down to that order;
//   no block reports ST_NO_BLOCK, a bad order reports ST_BAD_ORD, an unused func changes nothing
// free: merges with each free buddy found by walking its list, then pushes; rebuild: fills
//   the lists with max-order blocks, or with single pages when none fits; next item after the result
// synchronous reset empties all lists and clears counters; the link memory is not cleared
`include "assert_macros.svh"

module buddy_page_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // order[3:0], page[15:4]
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, block_page, free_pages, used_pages
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   localparam int TOP_ORD    = bpa_pkg::LARGEST_ORDER;
   localparam int POOL_PAGES = bpa_pkg::POOL_PAGES;
   localparam int PW  = $clog2(POOL_PAGES);
   localparam int LW  = PW + 1;
   localparam int OW  = $clog2(TOP_ORD + 2);
   localparam int NL  = TOP_ORD + 1;
   localparam logic [LW-1:0] EMPTY = LW'(POOL_PAGES);

   typedef enum logic [3:0] {
      S_IDLE, S_ASEARCH, S_APOP, S_APOPW, S_ASPLIT,
      S_FSTART, S_FRD, S_FCHK, S_FUNL, S_FPUSH,
      S_RBIG, S_RSMALL, S_DONE
   } state_type;

   state_type          state_ff;
   logic [LW-1:0]      heads_ff [NL];
   logic [LW-1:0]      links [POOL_PAGES];
   logic [LW-1:0]      rd_ff;
   logic [12:0]        count_ff, size_ff;
   logic [11:0]        start_ff;
   logic [12:0]        end_ff;
   logic [3:0]         ord_ff;
   logic [OW-1:0]      i_ff;
   logic [LW-1:0]      addr_ff, cur_ff, prev_ff, blk_ff, lim_ff;
   logic [LW:0]        steps_ff;
   logic [1:0]         st_ff;
   logic [11:0]        bp_ff;
   logic               any_ff;
   logic               rsp_v_ff;

   logic [3:0]  in_ord;
   logic [11:0] in_page;
   assign in_ord  = req_tdata[3:0];
   assign in_page = req_tdata[15:4];

   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;

   logic [12:0] used_w;
   assign used_w = (size_ff > count_ff) ? size_ff - count_ff : 13'd0;
   assign rsp_tdata = {used_w, count_ff, bp_ff, st_ff};

   logic [13:0] add_w;
   logic [12:0] amt_w;
   assign amt_w = 13'(1) << ord_ff;
   assign add_w = {1'b0, count_ff} + {1'b0, amt_w};

   logic [LW-1:0] sz_w;
   assign sz_w = LW'(1) << i_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_FRD || state_ff == S_APOP)
         rd_ff <= links[cur_ff[PW-1:0]];
      if (state_ff == S_ASPLIT && i_ff > OW'(ord_ff) &&
          (addr_ff + (sz_w >> 1)) < EMPTY)
         links[PW'(addr_ff + (sz_w >> 1))] <= heads_ff[i_ff - OW'(1)];
      if (state_ff == S_FUNL && prev_ff != EMPTY)
         links[prev_ff[PW-1:0]] <= rd_ff;
      if (state_ff == S_FPUSH)
         links[addr_ff[PW-1:0]] <= heads_ff[i_ff];
      if ((state_ff == S_RBIG && lim_ff >= addr_ff + blk_ff) ||
          (state_ff == S_RSMALL && lim_ff > addr_ff))
         links[addr_ff[PW-1:0]] <= heads_ff[state_ff == S_RBIG ? OW'(TOP_ORD) : OW'(0)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int k = 0; k < NL; k++) heads_ff[k] <= EMPTY;
         count_ff <= '0; size_ff <= '0; start_ff <= '0; end_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         if (csr_valid) begin
            if (csr_index == 1'(bpa_pkg::CSR_POOL_START)) start_ff <= csr_wdata[11:0];
            else end_ff <= csr_wdata;
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               ord_ff <= in_ord;
               st_ff <= bpa_pkg::ST_OK; bp_ff <= '0;
               addr_ff <= LW'(in_page);
               i_ff <= OW'(in_ord);
               if (req_tuser == bpa_pkg::FUNC_REBUILD) begin
                  for (int k = 0; k < NL; k++) heads_ff[k] <= EMPTY;
                  count_ff <= '0;
                  lim_ff <= (end_ff > 13'(POOL_PAGES)) ? EMPTY : LW'(end_ff);
                  size_ff <= (((end_ff > 13'(POOL_PAGES)) ? 13'(POOL_PAGES) : end_ff)
                              > 13'(start_ff)) ?
                             ((end_ff > 13'(POOL_PAGES)) ? 13'(POOL_PAGES) : end_ff)
                             - 13'(start_ff) : 13'd0;
                  blk_ff <= LW'(1) << TOP_ORD;
                  addr_ff <= (LW'(start_ff) + LW'((1 << TOP_ORD) - 1)) &
                             ~LW'((1 << TOP_ORD) - 1);
                  any_ff <= 1'b0;
                  state_ff <= S_RBIG;
               end else if (req_tuser == bpa_pkg::FUNC_NONE) begin
                  state_ff <= S_DONE;
               end else if (in_ord > 4'(TOP_ORD)) begin
                  st_ff <= bpa_pkg::ST_BAD_ORD; state_ff <= S_DONE;
               end else if (req_tuser == bpa_pkg::FUNC_ALLOC) begin
                  state_ff <= S_ASEARCH;
               end else if (LW'(in_page) >= EMPTY) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_FSTART;
               end
            end
            S_ASEARCH: begin
               if (i_ff > OW'(TOP_ORD)) begin
                  st_ff <= bpa_pkg::ST_NO_BLOCK; state_ff <= S_DONE;
               end else if (heads_ff[i_ff] < EMPTY) begin
                  cur_ff <= heads_ff[i_ff]; state_ff <= S_APOP;
               end else i_ff <= i_ff + OW'(1);
            end
            S_APOP: state_ff <= S_APOPW;
            S_APOPW: begin
               heads_ff[i_ff] <= rd_ff;
               addr_ff <= cur_ff; bp_ff <= cur_ff[11:0];
               count_ff <= (count_ff > amt_w) ? count_ff - amt_w : 13'd0;
               state_ff <= S_ASPLIT;
            end
            S_ASPLIT: begin
               if (i_ff > OW'(ord_ff)) begin
                  if ((addr_ff + (sz_w >> 1)) < EMPTY)
                     heads_ff[i_ff - OW'(1)] <= addr_ff + (sz_w >> 1);
                  i_ff <= i_ff - OW'(1);
               end else state_ff <= S_DONE;
            end
            S_FSTART: begin
               state_ff <= S_FPUSH;
               if (i_ff < OW'(TOP_ORD)) begin
                  cur_ff <= heads_ff[i_ff]; prev_ff <= EMPTY; steps_ff <= '0;
                  state_ff <= S_FRD;
               end
            end
            S_FRD: begin
               if (cur_ff >= EMPTY || steps_ff >= (LW+1)'(POOL_PAGES))
                  state_ff <= S_FPUSH;
               else state_ff <= S_FCHK;
            end
            S_FCHK: begin
               if (cur_ff == (addr_ff ^ sz_w)) state_ff <= S_FUNL;
               else begin
                  prev_ff <= cur_ff; cur_ff <= rd_ff;
                  steps_ff <= steps_ff + 1'b1; state_ff <= S_FRD;
               end
            end
            S_FUNL: begin
               if (prev_ff == EMPTY) heads_ff[i_ff] <= rd_ff;
               addr_ff <= addr_ff & ~sz_w;
               i_ff <= i_ff + OW'(1);
               state_ff <= S_FSTART;
            end
            S_FPUSH: begin
               // freed pages counted once per item, whatever the merges
               count_ff <= add_w[13] ? bpa_pkg::COUNT_MAX : add_w[12:0];
               heads_ff[i_ff] <= addr_ff; state_ff <= S_DONE;
            end
            S_RBIG: begin
               if (lim_ff >= addr_ff + blk_ff && addr_ff + blk_ff <= EMPTY) begin
                  heads_ff[OW'(TOP_ORD)] <= addr_ff;
                  count_ff <= count_ff + 13'(1 << TOP_ORD);
                  any_ff <= 1'b1;
                  addr_ff <= addr_ff + blk_ff;
               end else if (any_ff) state_ff <= S_DONE;
               else begin
                  addr_ff <= LW'(start_ff); state_ff <= S_RSMALL;
               end
            end
            S_RSMALL: begin
               if (lim_ff > addr_ff) begin
                  heads_ff[0] <= addr_ff;
                  count_ff <= count_ff + 13'd1;
                  addr_ff <= addr_ff + LW'(1);
               end else state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_v_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BPA_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_tready, "ready while busy")
   `BPA_ASSERT_NXT(a_done_rsp, clock, reset, state_ff == S_DONE, rsp_tvalid, "no result after done")
   `BPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_v_ff && !rsp_tready, rsp_v_ff, "result dropped")

endmodule
